// File: hdl/assert_macros.svh
// assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock, muted while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition that must never be seen at a rising clock
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// File: hdl/hcj_pkg.sv
`default_nettype none

package hcj_pkg;

	localparam int PIXEL_BITS = 8;
	localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

	localparam int GAIN_W = 16;
	localparam int HUE_W  = 16;
	localparam int FRAC_W = 16;
	localparam int GAIN_FRAC = 12;
	localparam int HUE_ONE = 1 << FRAC_W;

	// divider: radix-2 restoring, DIV_STEP quotient bits per stage
	localparam int DIV_QW     = 20;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = DIV_QW / DIV_STEP;
	localparam int DIV_DW     = PIXEL_BITS + 3;
	localparam int DIV_RW     = DIV_DW + 1;
	localparam int DIV_NW     = PIXEL_BITS + DIV_QW;

	localparam int S_W    = FRAC_W + 1;
	localparam int SX_W   = S_W + GAIN_W - GAIN_FRAC;
	localparam int FAC_W  = SX_W + 1;
	localparam int VQ_W   = PIXEL_BITS + GAIN_W;
	localparam int PROD_W = VQ_W + 1 + FAC_W;
	localparam int PIX_SHIFT = 2 * FRAC_W - (FRAC_W - GAIN_FRAC);

	localparam int BACK_STAGES = 5;
	localparam int NSTAGE = 1 + DIV_STAGES + BACK_STAGES;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		REG_GRAY,
		REG_HUE,
		REG_SAT,
		REG_VAL
	} reg_idx_t;

	typedef enum logic [2:0] {
		SEXT_0,
		SEXT_1,
		SEXT_2,
		SEXT_3,
		SEXT_4,
		SEXT_5,
		SEXT_6
	} sextant_t;

	typedef struct packed {
		logic gray_mode;
		logic signed [HUE_W-1:0] hue_shift;
		logic [GAIN_W-1:0] sat_gain;
		logic [GAIN_W-1:0] value_gain;
	} cfg_t;

	typedef struct packed {
		logic gray;
		logic [PIXEL_BITS-1:0] src;
		logic no_sat;
		logic no_hue;
	} side_t;

	typedef struct packed {
		logic [DIV_RW-1:0] rem;
		logic [DIV_STEP-1:0] q;
	} div_step_t;

	function automatic div_step_t div_step(input logic [DIV_RW-1:0] rem_i,
			input logic [DIV_DW-1:0] d, input logic [DIV_STEP-1:0] nbits);
		logic [DIV_RW-1:0] rem;
		logic [DIV_RW-1:0] sh;
		div_step_t res;
		rem = rem_i;
		res.q = '0;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			sh = {rem[DIV_RW-2:0], nbits[i]};
			if (sh >= {1'b0, d}) begin
				rem = sh - {1'b0, d};
				res.q[i] = 1'b1;
			end else begin
				rem = sh;
			end
		end
		res.rem = rem;
		return res;
	endfunction

	// Q12 value times Q16 factor, rounded half up to pixel units and clamped
	function automatic logic [PIXEL_BITS-1:0] to_pixel(input logic signed [PROD_W-1:0] prod);
		logic [PROD_W:0] sum;
		logic [PROD_W-PIX_SHIFT-1:0] u;
		logic [PIXEL_BITS-1:0] res;
		sum = {1'b0, prod} + (PROD_W + 1)'(1 << (PIX_SHIFT - 1));
		u = sum[PROD_W-1:PIX_SHIFT];
		if (prod <= 0)
			res = '0;
		else if (u > (PROD_W - PIX_SHIFT)'(PIX_MAX))
			res = PIX_MAX;
		else
			res = u[PIXEL_BITS-1:0];
		return res;
	endfunction

	// Q12 value at unit factor
	function automatic logic [PIXEL_BITS-1:0] round_v(input logic [VQ_W-1:0] vq);
		logic [VQ_W:0] sum;
		logic [VQ_W-GAIN_FRAC:0] u;
		logic [PIXEL_BITS-1:0] res;
		sum = {1'b0, vq} + (VQ_W + 1)'(1 << (GAIN_FRAC - 1));
		u = sum[VQ_W:GAIN_FRAC];
		if (u > (VQ_W - GAIN_FRAC + 1)'(PIX_MAX))
			res = PIX_MAX;
		else
			res = u[PIXEL_BITS-1:0];
		return res;
	endfunction

endpackage

`default_nettype wire

// File: hdl/hcj_if.sv
`default_nettype none

interface hcj_in_if;
	import hcj_pkg::*;
	logic valid;
	logic ready;
	logic [PIXEL_BITS-1:0] red_in;
	logic [PIXEL_BITS-1:0] green_in;
	logic [PIXEL_BITS-1:0] blue_in;
	modport source(output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface hcj_out_if;
	import hcj_pkg::*;
	logic valid;
	logic ready;
	logic [PIXEL_BITS-1:0] red_out;
	logic [PIXEL_BITS-1:0] green_out;
	logic [PIXEL_BITS-1:0] blue_out;
	modport source(output valid, output red_out, output green_out, output blue_out, input ready);
	modport sink(input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

`default_nettype wire

// File: hdl/hcj_cfg.sv
`default_nettype none

module hcj_cfg (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [hcj_pkg::APB_AW-1:0] paddr,
	input  wire logic [hcj_pkg::APB_DW-1:0] pwdata,
	output logic [hcj_pkg::APB_DW-1:0] prdata,
	output logic pready,
	output hcj_pkg::cfg_t cfg
);
	import hcj_pkg::*;

	cfg_t cfg_q;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gray_mode <= 1'b0;
			cfg_q.hue_shift <= '0;
			cfg_q.sat_gain <= GAIN_W'(1 << GAIN_FRAC);
			cfg_q.value_gain <= GAIN_W'(1 << GAIN_FRAC);
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_GRAY: cfg_q.gray_mode <= pwdata[0];
				REG_HUE:  cfg_q.hue_shift <= pwdata[HUE_W-1:0];
				REG_SAT:  cfg_q.sat_gain <= pwdata[GAIN_W-1:0];
				REG_VAL:  cfg_q.value_gain <= pwdata[GAIN_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GRAY: prdata = APB_DW'(cfg_q.gray_mode);
			REG_HUE:  prdata = APB_DW'(cfg_q.hue_shift);
			REG_SAT:  prdata = APB_DW'(cfg_q.sat_gain);
			REG_VAL:  prdata = APB_DW'(cfg_q.value_gain);
			default:  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/hcj_div.sv
`default_nettype none

module hcj_div (
	input  wire logic clk,
	input  wire logic [hcj_pkg::DIV_STAGES-1:0] en,
	input  wire logic [hcj_pkg::DIV_NW-1:0] n,
	input  wire logic [hcj_pkg::DIV_DW-1:0] d,
	output logic [hcj_pkg::DIV_QW-1:0] q
);
	import hcj_pkg::*;

	// remainder, dividend and divisor ride along to the next stage
	logic [DIV_RW-1:0] rem_s [DIV_STAGES-1];
	logic [DIV_QW-1:0] n_s   [DIV_STAGES-1];
	logic [DIV_DW-1:0] d_s   [DIV_STAGES-1];
	logic [DIV_QW-1:0] q_s   [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DIV_RW-1:0] rem_in;
		logic [DIV_QW-1:0] n_in;
		logic [DIV_DW-1:0] d_in;
		logic [DIV_QW-1:0] q_in;
		div_step_t st;

		if (k == 0) begin : g_first
			assign rem_in = DIV_RW'(n[DIV_NW-1:DIV_QW]);
			assign n_in = n[DIV_QW-1:0];
			assign d_in = d;
			assign q_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign n_in = n_s[k-1];
			assign d_in = d_s[k-1];
			assign q_in = q_s[k-1];
		end

		assign st = div_step(rem_in, d_in, n_in[DIV_QW-1-k*DIV_STEP -: DIV_STEP]);

		always_ff @(posedge clk) begin
			if (en[k])
				q_s[k] <= {q_in[DIV_QW-DIV_STEP-1:0], st.q};
		end

		if (k < DIV_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= st.rem;
					n_s[k] <= n_in;
					d_s[k] <= d_in;
				end
			end
		end
	end

	assign q = q_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: hdl/hcj_back.sv
`default_nettype none
`include "assert_macros.svh"

module hcj_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire hcj_pkg::cfg_t cfg,
	input  wire logic [hcj_pkg::BACK_STAGES-1:0] en,
	input  wire logic vld,
	input  wire hcj_pkg::side_t side,
	input  wire logic [hcj_pkg::S_W-1:0] qs,
	input  wire logic [hcj_pkg::S_W-1:0] qh,
	output logic [hcj_pkg::PIXEL_BITS-1:0] red,
	output logic [hcj_pkg::PIXEL_BITS-1:0] green,
	output logic [hcj_pkg::PIXEL_BITS-1:0] blue
);
	import hcj_pkg::*;

	localparam int SP_W = S_W + GAIN_W + 1;
	localparam int HS_W = S_W + 2;

	// s7: scale saturation and value, shift and wrap hue
	logic [S_W-1:0] s_c, h_c;
	logic [SP_W-1:0] sp_c;
	logic signed [HS_W-1:0] hsum_c;
	logic [S_W-1:0] hw_c;
	logic [SX_W-1:0] sx_s7;
	logic [S_W-1:0] hw_s7;
	logic [VQ_W-1:0] vq_s7;
	logic gray_s7;

	assign s_c = side.no_sat ? '0 : qs;
	assign h_c = side.no_hue ? '0 : qh;
	assign sp_c = SP_W'(s_c) * SP_W'(cfg.sat_gain) + SP_W'(1 << (GAIN_FRAC - 1));
	assign hsum_c = $signed({2'b00, h_c}) + HS_W'(cfg.hue_shift);

	always_comb begin
		if (hsum_c > $signed(HS_W'(HUE_ONE)))
			hw_c = S_W'(hsum_c - $signed(HS_W'(HUE_ONE)));
		else if (hsum_c < 0)
			hw_c = S_W'(hsum_c + $signed(HS_W'(HUE_ONE)));
		else
			hw_c = S_W'(hsum_c);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sx_s7 <= sp_c[GAIN_FRAC +: SX_W];
			hw_s7 <= hw_c;
			vq_s7 <= VQ_W'(side.src) * VQ_W'(cfg.value_gain);
			gray_s7 <= side.gray;
		end
	end

	// s8: sextant and fraction
	logic [S_W+2:0] h6_c;
	sextant_t idx_s8;
	logic [FRAC_W-1:0] f_s8;
	logic [SX_W-1:0] sx_s8;
	logic signed [FAC_W-1:0] pf_s8;
	logic [VQ_W-1:0] vq_s8;
	logic gray_s8;

	assign h6_c = (S_W + 3)'(hw_s7) * (S_W + 3)'(6);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			idx_s8 <= sextant_t'(h6_c[FRAC_W +: 3]);
			f_s8 <= h6_c[FRAC_W-1:0];
			sx_s8 <= sx_s7;
			pf_s8 <= $signed(FAC_W'(HUE_ONE)) - $signed({1'b0, sx_s7});
			vq_s8 <= vq_s7;
			gray_s8 <= gray_s7;
		end
	end

	// s9: q and t factors
	logic [SX_W+FRAC_W-1:0] qm_c;
	logic [S_W-1:0] fc_c;
	logic [SX_W+S_W-1:0] tm_c;
	sextant_t idx_s9;
	logic signed [FAC_W-1:0] pf_s9, qf_s9, tf_s9;
	logic [VQ_W-1:0] vq_s9;
	logic gray_s9;

	assign qm_c = (SX_W + FRAC_W)'(sx_s8) * (SX_W + FRAC_W)'(f_s8);
	assign fc_c = S_W'(HUE_ONE) - {1'b0, f_s8};
	assign tm_c = (SX_W + S_W)'(sx_s8) * (SX_W + S_W)'(fc_c);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			idx_s9 <= idx_s8;
			pf_s9 <= pf_s8;
			qf_s9 <= $signed(FAC_W'(HUE_ONE)) - $signed({1'b0, qm_c[FRAC_W +: SX_W]});
			tf_s9 <= $signed(FAC_W'(HUE_ONE)) - $signed({1'b0, tm_c[FRAC_W +: SX_W]});
			vq_s9 <= vq_s8;
			gray_s9 <= gray_s8;
		end
	end

	// s10: scale value by each factor
	logic signed [VQ_W:0] vqs_c;
	sextant_t idx_s10;
	logic signed [PROD_W-1:0] pp_s10, qp_s10, tp_s10;
	logic [VQ_W-1:0] vq_s10;
	logic gray_s10;

	assign vqs_c = $signed({1'b0, vq_s9});

	always_ff @(posedge clk) begin
		if (en[3]) begin
			idx_s10 <= idx_s9;
			pp_s10 <= vqs_c * pf_s9;
			qp_s10 <= vqs_c * qf_s9;
			tp_s10 <= vqs_c * tf_s9;
			vq_s10 <= vq_s9;
			gray_s10 <= gray_s9;
		end
	end

	// s11: round, clamp and route channels
	logic [PIXEL_BITS-1:0] v_c, p_c, q_c, t_c;
	logic [PIXEL_BITS-1:0] r_c, g_c, b_c;
	logic [PIXEL_BITS-1:0] red_s11, green_s11, blue_s11;
	logic gray_s11;

	assign v_c = round_v(vq_s10);
	assign p_c = to_pixel(pp_s10);
	assign q_c = to_pixel(qp_s10);
	assign t_c = to_pixel(tp_s10);

	always_comb begin
		case (idx_s10) inside
			SEXT_0:         begin r_c = v_c; g_c = t_c; b_c = p_c; end
			SEXT_1:         begin r_c = q_c; g_c = v_c; b_c = p_c; end
			SEXT_2:         begin r_c = p_c; g_c = v_c; b_c = t_c; end
			SEXT_3:         begin r_c = p_c; g_c = q_c; b_c = v_c; end
			SEXT_4:         begin r_c = t_c; g_c = p_c; b_c = v_c; end
			SEXT_5, SEXT_6: begin r_c = v_c; g_c = p_c; b_c = q_c; end
			default:        begin r_c = v_c; g_c = p_c; b_c = q_c; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			red_s11 <= gray_s10 ? v_c : r_c;
			green_s11 <= gray_s10 ? '0 : g_c;
			blue_s11 <= gray_s10 ? '0 : b_c;
			gray_s11 <= gray_s10;
		end
	end

	assign red = red_s11;
	assign green = green_s11;
	assign blue = blue_s11;

	`ASSERT_NEVER(a_gray_zero, clk, arst_n, vld && gray_s11 && (green_s11 != '0 || blue_s11 != '0), "gray word with nonzero green or blue")

endmodule

`default_nettype wire

// File: hdl/hsv_color_jitter_top.sv
// HSV color jitter: takes one 8-bit RGB pixel per word and returns one adjusted pixel. The
// pixel goes to HSV, saturation and value are scaled by the Q4.12 gains, the signed hue
// offset (1/65536 turn) is added with one wrap, then it goes back to RGB clamped to 0..255.
// Gray mode scales red by the value gain only and drives green and blue to zero. Fully
// pipelined: a new word can enter every clock while the output is not stalled, and a word
// passes through one front stage, five stages of the radix-16 hue and saturation dividers and
// five stages of gain multiply and back-conversion. Output stalls back up stage by stage, so
// bubbles in the pipe still absorb input. Registers (APB, 32-bit data): 0x0 gray_mode,
// 0x4 hue_shift, 0x8 sat_gain, 0xC value_gain; write them only while the pipe is empty.
`default_nettype none
`include "assert_macros.svh"

module hsv_color_jitter_top (
	input  wire logic clk,
	input  wire logic arst_n,
	hcj_in_if.sink pix_in,
	hcj_out_if.source pix_out,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [hcj_pkg::APB_AW-1:0] paddr,
	input  wire logic [hcj_pkg::APB_DW-1:0] pwdata,
	output logic [hcj_pkg::APB_DW-1:0] prdata,
	output logic pready
);
	import hcj_pkg::*;

	localparam int NUM_W = DIV_DW + 1;

	cfg_t cfg;

	hcj_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// per-stage valid and load enables; a stage loads when empty or when it drains
	logic [NSTAGE-1:0] vld_s;
	logic [NSTAGE-1:0] en;

	always_comb begin
		en[NSTAGE-1] = !vld_s[NSTAGE-1] || pix_out.ready;
		for (int k = NSTAGE - 2; k >= 0; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0])
				vld_s[0] <= pix_in.valid;
			for (int k = 1; k < NSTAGE; k++) begin
				if (en[k])
					vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign pix_in.ready = en[0];
	assign pix_out.valid = vld_s[NSTAGE-1];

	// s1: max, min and hue numerator
	logic [PIXEL_BITS-1:0] r_c, g_c, b_c, mx_c, mn_c, dl_c;
	logic signed [NUM_W-1:0] num_c, rx_c, gx_c, bx_c, dx_c;
	logic [DIV_DW-1:0] numu_c;
	side_t side_c;
	side_t side_s [DIV_STAGES+1];
	logic [DIV_NW-1:0] ns_s1, nh_s1;
	logic [DIV_DW-1:0] ds_s1, dh_s1;

	assign r_c = pix_in.red_in;
	assign g_c = pix_in.green_in;
	assign b_c = pix_in.blue_in;
	assign mx_c = (r_c > g_c) ? ((r_c > b_c) ? r_c : b_c) : ((g_c > b_c) ? g_c : b_c);
	assign mn_c = (r_c < g_c) ? ((r_c < b_c) ? r_c : b_c) : ((g_c < b_c) ? g_c : b_c);
	assign dl_c = mx_c - mn_c;
	assign rx_c = $signed(NUM_W'(r_c));
	assign gx_c = $signed(NUM_W'(g_c));
	assign bx_c = $signed(NUM_W'(b_c));
	assign dx_c = $signed(NUM_W'(dl_c));

	always_comb begin
		if (r_c == mx_c)
			num_c = gx_c - bx_c;
		else if (g_c == mx_c)
			num_c = (dx_c <<< 1) + bx_c - rx_c;
		else
			num_c = (dx_c <<< 2) + rx_c - gx_c;
		if (num_c < 0)
			num_c = num_c + dx_c * NUM_W'(6);
	end

	assign numu_c = num_c[DIV_DW-1:0];

	assign side_c.gray = cfg.gray_mode;
	assign side_c.src = cfg.gray_mode ? r_c : mx_c;
	assign side_c.no_sat = cfg.gray_mode || (mx_c == '0);
	assign side_c.no_hue = cfg.gray_mode || (dl_c == '0);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ns_s1 <= DIV_NW'({dl_c, FRAC_W'(0)});
			ds_s1 <= DIV_DW'(mx_c);
			nh_s1 <= DIV_NW'({numu_c, FRAC_W'(0)}) + DIV_NW'(dl_c) * DIV_NW'(3);
			dh_s1 <= DIV_DW'(dl_c) * DIV_DW'(6);
		end
	end

	// s2..s6: saturation and hue dividers, side data alongside
	logic [DIV_QW-1:0] qs, qh;

	hcj_div u_div_sat (
		.clk(clk),
		.en(en[DIV_STAGES:1]),
		.n(ns_s1),
		.d(ds_s1),
		.q(qs)
	);

	hcj_div u_div_hue (
		.clk(clk),
		.en(en[DIV_STAGES:1]),
		.n(nh_s1),
		.d(dh_s1),
		.q(qh)
	);

	always_ff @(posedge clk) begin
		if (en[0])
			side_s[0] <= side_c;
		for (int k = 1; k <= DIV_STAGES; k++) begin
			if (en[k])
				side_s[k] <= side_s[k-1];
		end
	end

	// s7..s11: gains, hue shift and back-conversion
	hcj_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.en(en[NSTAGE-1:DIV_STAGES+1]),
		.vld(vld_s[NSTAGE-1]),
		.side(side_s[DIV_STAGES]),
		.qs(qs[S_W-1:0]),
		.qh(qh[S_W-1:0]),
		.red(pix_out.red_out),
		.green(pix_out.green_out),
		.blue(pix_out.blue_out)
	);

	`ASSERT_CLK(a_empty_out_ready, clk, arst_n, !vld_s[NSTAGE-1] |-> pix_in.ready, "input blocked with output stage empty")
	`ASSERT_CLK(a_held_stage, clk, arst_n, (vld_s[0] && !en[0]) |=> vld_s[0], "stalled front word dropped")

endmodule

`default_nettype wire
